@@ rtl/alst_pkg.sv @@
// Shared types and constants for the access location schedule table.
// Used by alst_table and access_location_schedule_table.
package alst_pkg;

  // Default number of logical indexes tracked
  localparam int DEF_ENTRIES = 1024;

  // Field widths of the item channels
  localparam int IDX_W = 10;
  localparam int LOC_W = 11;

  // Epoch tag stored with each table word; tag zero marks a cleared entry
  localparam int EPOCH_W = 8;

  typedef enum logic [1:0] {
    OP_ACCESS  = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic             overflow;
  } out_item_t;

endpackage

@@ rtl/alst_table.sv @@
// Location table memory: one write port, one registered read port with
// write bypass, and a clearing sweep run after reset or on request. Uses alst_pkg.
module alst_table
  import alst_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_req,
  output logic                           busy,
  input  logic                           rd_en,
  input  logic [$clog2(ENTRIES)-1:0]     rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(ENTRIES)-1:0]     wr_addr,
  input  logic [EPOCH_W+$clog2(ENTRIES)-1:0] wr_data,
  output logic [EPOCH_W+$clog2(ENTRIES)-1:0] rd_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam int DW = EPOCH_W + AW;

  logic [DW-1:0] mem [ENTRIES];

  logic          busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [DW-1:0] rd_r;
  logic          byp_hit_r;
  logic [DW-1:0] byp_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;

  // Sweep writes take the port while busy
  always_comb begin
    if (busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  // Memory array: write, then registered read of the old word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Bypass when a read and a write hit the same word in one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (rd_en) begin
      byp_hit_r <= mem_we && (mem_wa == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= mem_wd;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_r;

  // Clearing sweep, one word a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      if (clr_addr_r == AW'(ENTRIES - 1)) begin
        busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end else if (clr_req) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/access_location_schedule_table.sv @@
// Top level of the access location schedule table: item pipeline, epoch
// and access counter. Uses alst_pkg and alst_table.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_item  (op, index)
//   out_    | output    | out_valid/out_stall| out_item (location, overflow)
//
// One item per cycle unless stalled: the table read happens at acceptance,
// the input stage resolves the location and writes the table, then the result
// register follows. After reset a sweep clears the table while in_stall is high.
// Restart bumps an epoch tag instead of rewriting the table; every 255th
// restart runs the same clearing sweep.
// A stalled output holds the pipeline stage and stalls the input.
module access_location_schedule_table
  import alst_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int DW   = EPOCH_W + AW;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  logic                s1_valid_r;
  in_item_t            s1_item_r;
  logic                s1_inrange_r;
  logic [EPOCH_W-1:0]  epoch_r;
  logic [CNTW-1:0]     count_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                busy;
  logic                in_acc;
  logic                s1_adv;
  logic                s1_wrap;
  logic                in_range;
  logic [DW-1:0]       rd_data;
  logic [EPOCH_W-1:0]  rd_tag;
  logic [AW-1:0]       rd_cnt;
  logic [LOC_W-1:0]    cur_loc;
  logic                ovf;
  logic                wr_en;
  logic [DW-1:0]       wr_data;
  out_item_t           res;

  // Handshake
  assign s1_adv  = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_wrap = s1_valid_r && (s1_item_r.op == OP_RESTART) && (epoch_r == EPOCH_MAX);
  assign in_stall = busy || (s1_valid_r && !s1_adv) || s1_wrap;
  assign in_acc   = in_valid && !in_stall;
  assign in_range = 32'(in_item.index) < 32'(ENTRIES);

  alst_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_req (s1_adv && s1_wrap),
    .busy    (busy),
    .rd_en   (in_acc),
    .rd_addr (AW'(in_item.index)),
    .wr_en   (wr_en),
    .wr_addr (AW'(s1_item_r.index)),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r    <= in_item;
      s1_inrange_r <= in_range;
    end
  end

  // Resolve location: a word tagged with the live epoch holds a fresh slot
  assign rd_tag  = rd_data[DW-1:AW];
  assign rd_cnt  = rd_data[AW-1:0];
  assign cur_loc = (rd_tag == epoch_r) ? LOC_W'(32'(ENTRIES) + 32'(rd_cnt))
                                       : LOC_W'(s1_item_r.index);
  assign ovf     = (count_r == CNTW'(ENTRIES));
  assign wr_en   = s1_adv && (s1_item_r.op == OP_ACCESS) && s1_inrange_r && !ovf;
  assign wr_data = {epoch_r, AW'(count_r)};

  always_comb begin
    res = '0;
    case (s1_item_r.op)
      OP_ACCESS: begin
        if (s1_inrange_r) begin
          res.location = cur_loc;
          res.overflow = ovf;
        end
      end
      OP_DRAIN: begin
        if (s1_inrange_r) begin
          res.location = cur_loc;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Epoch and access count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_W'(1);
      count_r <= '0;
    end else if (s1_adv) begin
      if (s1_item_r.op == OP_RESTART) begin
        epoch_r <= s1_wrap ? EPOCH_W'(1) : epoch_r + EPOCH_W'(1);
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + CNTW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
